// ===== hdl/gcmp_pkg.sv =====
`timescale 1ns / 1ps

package gcmp_pkg;

  localparam int COEF_W    = 9;
  localparam int PROD_W    = 17;
  localparam int MODULUS   = 257;
  localparam int OUT_LANES = 8;
  localparam int MAX_EMIT  = 16;
  localparam int GRAY_W    = 32;

  localparam int COUNTER_BITS_DEF = 32;
  localparam int WORDS_DEF        = 16;
  localparam int LANES_DEF        = 8;

  typedef enum logic [1:0] {
    MODE_LOAD_TABLE   = 2'd0,
    MODE_LOAD_PRODUCT = 2'd1,
    MODE_SET_COUNTER  = 2'd2,
    MODE_STEP         = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [10:0]       address;
    logic [31:0]       gray_count;
    logic [31:0]       start_value;
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
    logic [COEF_W-1:0] c7;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        word_index;
    logic              last;
    logic [31:0]       counter_out;
    logic [COEF_W-1:0] p0;
    logic [COEF_W-1:0] p1;
    logic [COEF_W-1:0] p2;
    logic [COEF_W-1:0] p3;
    logic [COEF_W-1:0] p4;
    logic [COEF_W-1:0] p5;
    logic [COEF_W-1:0] p6;
    logic [COEF_W-1:0] p7;
  } out_item_t;

  // sideband that travels with one word to the output stage
  typedef struct packed {
    logic        emit;
    logic        last;
    logic [3:0]  word_index;
    logic [31:0] counter_out;
  } word_tag_t;

  // 0..511 into 0..256
  function automatic logic [COEF_W-1:0] reduce_load(input logic [COEF_W-1:0] v);
    return (v >= COEF_W'(MODULUS)) ? COEF_W'(v - COEF_W'(MODULUS)) : v;
  endfunction

  // x <= 256*256; 256 = -1 mod 257, so x = lo - hi, one correction
  function automatic logic [COEF_W-1:0] reduce_product(input logic [PROD_W-1:0] x);
    logic [COEF_W:0] diff;
    diff = {2'b00, x[7:0]} - {1'b0, x[16:8]};
    if (diff[COEF_W]) begin
      return COEF_W'(diff + (COEF_W + 1)'(MODULUS));
    end
    return COEF_W'(diff);
  endfunction

  // trailing zero count, 32 when the word is zero
  function automatic logic [5:0] trailing_zeros(input logic [GRAY_W-1:0] g);
    logic [5:0] n;
    n = 6'd32;
    for (int i = GRAY_W - 1; i >= 0; i--) begin
      if (g[i]) begin
        n = 6'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [COEF_W-1:0] in_coef(input in_item_t it, input int j);
    logic [COEF_W-1:0] v;
    case (j)
      0:       v = it.c0;
      1:       v = it.c1;
      2:       v = it.c2;
      3:       v = it.c3;
      4:       v = it.c4;
      5:       v = it.c5;
      6:       v = it.c6;
      7:       v = it.c7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic out_item_t out_set_lane(input out_item_t it, input int j,
                                             input logic [COEF_W-1:0] v);
    out_item_t r;
    r = it;
    case (j)
      0:       r.p0 = v;
      1:       r.p1 = v;
      2:       r.p2 = v;
      3:       r.p3 = v;
      4:       r.p4 = v;
      5:       r.p5 = v;
      6:       r.p6 = v;
      7:       r.p7 = v;
      default: r = it;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/gcmp_lane.sv =====
`timescale 1ns / 1ps

// One coefficient lane: registered 9x9 multiply, then reduction mod 257.
module gcmp_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gcmp_pkg::COEF_W-1:0] prod_coef,
  input  logic [gcmp_pkg::COEF_W-1:0] tab_coef,
  output logic [gcmp_pkg::COEF_W-1:0] res
);
  import gcmp_pkg::*;

  logic [2*COEF_W-1:0] full;
  logic [PROD_W-1:0]   mult_r;

  assign full = prod_coef * tab_coef;

  always_ff @(posedge clk) begin
    if (en) begin
      mult_r <= PROD_W'(full);
    end
  end

  assign res = reduce_product(mult_r);

endmodule

// ===== hdl/gcmp_merge.sv =====
`timescale 1ns / 1ps

// Gathers the lane results into one result item and holds it for the sink.
module gcmp_merge #(
  parameter int LANES = gcmp_pkg::LANES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  gcmp_pkg::word_tag_t              tag,
  input  logic [LANES*gcmp_pkg::COEF_W-1:0] lane_res,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcmp_pkg::out_item_t              out_item
);
  import gcmp_pkg::*;

  logic [COEF_W-1:0] lane_p [OUT_LANES];
  out_item_t         item_nxt;
  out_item_t         item_r;
  logic              valid_r;
  logic              valid_nxt;

  // lanes past the result width are dropped, missing ones read as zero
  for (genvar j = 0; j < OUT_LANES; j++) begin : g_pick
    if (j < LANES) begin : g_have
      assign lane_p[j] = lane_res[j*COEF_W +: COEF_W];
    end else begin : g_none
      assign lane_p[j] = '0;
    end
  end

  always_comb begin
    item_nxt             = '0;
    item_nxt.word_index  = tag.word_index;
    item_nxt.last        = tag.last;
    item_nxt.counter_out = tag.counter_out;
    for (int j = 0; j < OUT_LANES; j++) begin
      item_nxt = out_set_lane(item_nxt, j, lane_p[j]);
    end
  end

  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== hdl/gray_counter_modular_product_update.sv =====
// Loads and set-counter items are taken without a stall and give no result.
// A step item is taken, then the block stalls its input while one product word
// per cycle is read, multiplied and written back, unless the sink stalls.
// The first result word goes through the read registers, the lane product
// register and the output register before it leaves the block.
// Reset (rst_n low, synchronous) clears counter and control, not the stores.
`timescale 1ns / 1ps

module gray_counter_modular_product_update #(
  parameter int COUNTER_BITS = gcmp_pkg::COUNTER_BITS_DEF,
  parameter int WORDS        = gcmp_pkg::WORDS_DEF,
  parameter int LANES        = gcmp_pkg::LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gcmp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gcmp_pkg::out_item_t out_item
);
  import gcmp_pkg::*;

  localparam int IDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CB_W      = $clog2(COUNTER_BITS);
  localparam int TAB_DEPTH = COUNTER_BITS * 2 * WORDS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int ROW_W     = LANES * COEF_W;
  localparam int EMIT      = (WORDS < MAX_EMIT) ? WORDS : MAX_EMIT;

  // control
  state_t            state_r;
  state_t            state_nxt;
  logic              in_accept;
  logic              issue_en;
  logic              advance;
  mode_t             in_mode;

  // counter and step decode
  logic [COUNTER_BITS-1:0] counter_r;
  logic [5:0]              flip;
  logic [CB_W-1:0]         flip_idx;
  logic                    flip_nv;
  logic                    step_go;
  logic [TAB_AW-1:0]       base_r;

  // pipeline: issue -> read data -> lane product -> write back / output
  logic [IDX_W-1:0] issue_w_r;
  logic [IDX_W-1:0] w1_r;
  logic [IDX_W-1:0] w2_r;
  logic             v1_r;
  logic             v2_r;
  logic             issue_last;
  logic             w2_last;

  // stores
  logic [ROW_W-1:0]  prod_mem [WORDS];
  logic [ROW_W-1:0]  tab_mem  [TAB_DEPTH];
  logic [ROW_W-1:0]  prod_rd_r;
  logic [ROW_W-1:0]  tab_rd_r;
  logic [TAB_AW-1:0] tab_rd_addr;

  // load path
  logic [5:0]        ld_bit;
  logic [3:0]        ld_word;
  logic [TAB_AW-1:0] tab_ld_addr;
  logic              tab_we;
  logic              prod_ld;
  logic [ROW_W-1:0]  load_row;

  // write back
  logic              wb_en;
  logic              prod_we;
  logic [IDX_W-1:0]  prod_wr_idx;
  logic [ROW_W-1:0]  prod_wr_row;
  logic [ROW_W-1:0]  lane_res;
  word_tag_t         tag;

  assign in_mode   = mode_t'(in_item.mode);
  assign in_accept = in_valid && !in_stall;

  // everything from read to output moves only when the output register
  // is free or being emptied this cycle
  assign advance = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // Step decode: flip the bit named by the trailing zeros of the Gray count
  // ---------------------------------------------------------------------
  assign flip     = trailing_zeros(in_item.gray_count);
  assign flip_idx = CB_W'(flip);
  assign flip_nv  = ~counter_r[flip_idx];
  assign step_go  = (in_mode == MODE_STEP) && (in_item.gray_count != '0) &&
                    (7'(flip) < 7'(COUNTER_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (in_accept && in_mode == MODE_SET_COUNTER) begin
      counter_r <= COUNTER_BITS'(in_item.start_value);
    end else if (in_accept && step_go) begin
      counter_r <= counter_r ^ (COUNTER_BITS'(1) << flip_idx);
    end
  end

  // first table word of the vector for (bit, new value)
  always_ff @(posedge clk) begin
    if (in_accept && step_go) begin
      base_r <= TAB_AW'({flip_idx, flip_nv}) * TAB_AW'(WORDS);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign issue_last = (issue_w_r == IDX_W'(WORDS - 1));
  assign w2_last    = (w2_r == IDX_W'(WORDS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && step_go) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (advance && issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (advance && v2_r && w2_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    issue_en = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_ISSUE: issue_en = 1'b1;
      ST_DRAIN: issue_en = 1'b0;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        v1_r <= issue_en;
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && step_go) begin
      issue_w_r <= '0;
    end else if (advance && issue_en && !issue_last) begin
      issue_w_r <= issue_w_r + IDX_W'(1);
    end
    if (advance) begin
      w1_r <= issue_w_r;
      w2_r <= w1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Load path: lanes reduced to canonical residues; out-of-range ignored
  // ---------------------------------------------------------------------
  assign ld_bit      = in_item.address[10:5];
  assign ld_word     = in_item.address[3:0];
  assign tab_ld_addr = TAB_AW'({CB_W'(ld_bit), in_item.address[4]}) * TAB_AW'(WORDS) +
                       TAB_AW'(ld_word);
  assign tab_we      = in_accept && (in_mode == MODE_LOAD_TABLE) &&
                       (7'(ld_bit) < 7'(COUNTER_BITS)) && (7'(ld_word) < 7'(WORDS));
  assign prod_ld     = in_accept && (in_mode == MODE_LOAD_PRODUCT) &&
                       (12'(in_item.address) < 12'(WORDS));

  for (genvar j = 0; j < LANES; j++) begin : g_load
    if (j < OUT_LANES) begin : g_port
      assign load_row[j*COEF_W +: COEF_W] = reduce_load(in_coef(in_item, j));
    end else begin : g_zero
      assign load_row[j*COEF_W +: COEF_W] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Stores. Write back and loads never meet: loads only while idle.
  // ---------------------------------------------------------------------
  assign tab_rd_addr = base_r + TAB_AW'(issue_w_r);

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_ld_addr] <= load_row;
    end
    if (advance) begin
      tab_rd_r <= tab_mem[tab_rd_addr];
    end
  end

  assign wb_en       = advance && v2_r;
  assign prod_we     = wb_en || prod_ld;
  assign prod_wr_idx = wb_en ? w2_r : in_item.address[IDX_W-1:0];
  assign prod_wr_row = wb_en ? lane_res : load_row;

  always_ff @(posedge clk) begin
    if (prod_we) begin
      prod_mem[prod_wr_idx] <= prod_wr_row;
    end
    if (advance) begin
      prod_rd_r <= prod_mem[issue_w_r];
    end
  end

  // ---------------------------------------------------------------------
  // Lanes
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    gcmp_lane u_lane (
      .clk       (clk),
      .en        (advance),
      .prod_coef (prod_rd_r[j*COEF_W +: COEF_W]),
      .tab_coef  (tab_rd_r[j*COEF_W +: COEF_W]),
      .res       (lane_res[j*COEF_W +: COEF_W])
    );
  end

  // ---------------------------------------------------------------------
  // Output: only the first EMIT words leave the block
  // ---------------------------------------------------------------------
  assign tag.emit        = v2_r && (7'(w2_r) < 7'(EMIT));
  assign tag.last        = (w2_r == IDX_W'(EMIT - 1));
  assign tag.word_index  = 4'(w2_r);
  assign tag.counter_out = 32'(counter_r);

  gcmp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && tag.emit),
    .tag       (tag),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/gcmp_checker.sv =====
`timescale 1ns / 1ps

module gcmp_checker #(
  parameter int WORDS = gcmp_pkg::WORDS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gcmp_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input gcmp_pkg::out_item_t out_item
);
  import gcmp_pkg::*;

  localparam int EMIT = (WORDS < MAX_EMIT) ? WORDS : MAX_EMIT;

  // a held item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // a step on an odd Gray count always flips bit 0, so the block goes busy
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.mode == MODE_STEP && in_item.gray_count[0]
    |=> in_stall)
    else $error("step item did not make the block busy");

  // last marks exactly the final emitted word
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last == (out_item.word_index == 4'(EMIT - 1))))
    else $error("last flag on wrong word");

  // words of one step come in order and carry one counter value
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last
    |=> !out_valid || (out_item.word_index == 4'($past(out_item.word_index) + 4'd1)))
    else $error("word index out of sequence");

  a_ctr_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last
    |=> !out_valid || (out_item.counter_out == $past(out_item.counter_out)))
    else $error("counter changed within a step");

endmodule

bind gray_counter_modular_product_update gcmp_checker #(
  .WORDS (WORDS)
) u_gcmp_checker (.*);
